// File: hw/rtl/lfm_chirp_pulse_generator_top_macros.svh
// Assertion macros for the chirp pulse generator.
// Used by the top level; expects signals named clk and arst_n in scope.
`ifndef LFM_CHIRP_PULSE_GENERATOR_TOP_MACROS_SVH
`define LFM_CHIRP_PULSE_GENERATOR_TOP_MACROS_SVH
// Checked only while out of reset.
`define LFM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Checked at every edge, reset included.
`define LFM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/lfm_pkg.sv
// Shared types and constants of the chirp pulse generator.
// No dependencies; imported by every module of the block.
package lfm_pkg;

	localparam int PERIOD_W   = 24;
	localparam int PULSE_W    = 24;
	localparam int CHIRP_W    = 32;
	localparam int AMP_W      = 15;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam int S_TDATA_W  = 8;

	localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd1000;
	localparam logic [PULSE_W-1:0]  PULSE_RST  = 24'd100;
	localparam logic [CHIRP_W-1:0]  CHIRP_RST  = 32'd0;
	localparam logic [AMP_W-1:0]    AMP_RST    = 15'd32767;

	// pi/2 in Q30, and the Taylor divisors (2n)(2n+1) of the sine series.
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam int unsigned TAYLOR_DIV [5] = '{6, 20, 42, 72, 110};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD = 8'd0,
		REG_PULSE  = 8'd1,
		REG_CHIRP  = 8'd2,
		REG_AMP    = 8'd3
	} cfg_reg_t;

	// Per-item control passed from the sequencer to the output pipeline.
	typedef struct packed {
		logic       in_pulse;
		logic       period_start;
		logic [1:0] quad;
	} lfm_ctl_t;

	// Result flags; in_pulse sits in the lowest bit.
	typedef struct packed {
		logic period_start;
		logic in_pulse;
	} lfm_flags_t;

endpackage

// File: hw/rtl/lfm_chirp_pulse_generator_top.sv
// Linear-FM chirp pulse train source.
// Input stream (s_*): one item per output sample; s_tdata[0] is restart, which makes
//   that sample the first of a new repetition period.
// Output stream (m_*): one item per input item, in order. m_tdata carries i_sample
//   in the low SAMPLE_BITS and q_sample above it, zero padded to whole bytes;
//   m_tuser[0] is in_pulse and m_tuser[1] is period_start.
// Configuration (cfg_*): cfg_index selects period_length, pulse_length, chirp_step or
//   amplitude; cfg_ready is always high. Write only while the stream is idle.
// Throughput is one item per clock while the receiver keeps m_tready high. An accepted item
// passes three register stages: the accepting edge updates the accumulators and registers
// the synchronous sine ROM read, then the amplitude product is registered, and last the
// rounded output register, which raises m_tvalid, is loaded.
// The counter and accumulators update in the accept cycle, so consecutive items
// never wait on each other.
// When the receiver stalls, the pipeline keeps filling its empty stages and s_tready
// drops only once all three are full. Reset clears the counter, both accumulators
// and all valid flags, and loads the registers with 1000, 100, 0 and 32767.
`include "lfm_chirp_pulse_generator_top_macros.svh"

module lfm_chirp_pulse_generator_top #(
	parameter int PHASE_BITS      = 32,
	parameter int COUNT_BITS      = 24,
	parameter int SAMPLE_BITS     = 16,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [lfm_pkg::S_TDATA_W-1:0]            s_tdata,  // [0] restart
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,  // i_sample, q_sample
	output logic [1:0]                               m_tuser,  // in_pulse, period_start
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [lfm_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [lfm_pkg::CFG_DATA_W-1:0]           cfg_data
);
	import lfm_pkg::*;

	localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

	lfm_ctl_t                      ctl;
	lfm_flags_t                    flags;
	logic [SINE_TABLE_BITS-1:0]    rom_addr;
	logic [SAMPLE_BITS-2:0]        rom_a;
	logic [SAMPLE_BITS-2:0]        rom_b;
	logic [AMP_W-1:0]              amplitude;
	logic                          take;
	logic signed [SAMPLE_BITS-1:0] i_sample;
	logic signed [SAMPLE_BITS-1:0] q_sample;

	assign cfg_ready = 1'b1;
	assign s_tready  = take;

	lfm_seq #(
		.PHASE_BITS      (PHASE_BITS),
		.COUNT_BITS      (COUNT_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (s_tvalid && take),
		.restart   (s_tdata[0]),
		.ctl       (ctl),
		.rom_addr  (rom_addr),
		.amplitude (amplitude)
	);

	lfm_sine_rom #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_rom (
		.clk  (clk),
		.en   (take),
		.addr (rom_addr),
		.rd_a (rom_a),
		.rd_b (rom_b)
	);

	lfm_scale #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.take      (take),
		.ctl       (ctl),
		.rom_a     (rom_a),
		.rom_b     (rom_b),
		.amplitude (amplitude),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.i_sample  (i_sample),
		.q_sample  (q_sample),
		.flags     (flags)
	);

	assign m_tdata = TDATA_W'({q_sample, i_sample});
	assign m_tuser = flags;

	// Samples outside the chirp must be exactly zero.
	`LFM_ASSERT(a_zero_outside_pulse, m_tvalid && !m_tuser[0] |-> m_tdata == '0, "nonzero sample outside pulse")
	// An empty output register always lets the pipeline take an item.
	`LFM_ASSERT_ALWAYS(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")
	// The first chirp sample has phase zero, so both components are non-negative.
	`LFM_ASSERT(a_first_sample_phase, m_tvalid && m_tuser[1] && m_tuser[0] |-> !m_tdata[SAMPLE_BITS-1] && !m_tdata[2*SAMPLE_BITS-1], "pulse start not at zero phase")

endmodule

// File: hw/rtl/lfm_seq.sv
// Sample counter, phase and frequency accumulators and configuration registers.
// Depends on lfm_pkg.
module lfm_seq #(
	parameter int PHASE_BITS      = 32,
	parameter int COUNT_BITS      = 24,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lfm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             acc,
	input  logic                             restart,
	output lfm_pkg::lfm_ctl_t                ctl,
	output logic [SINE_TABLE_BITS-1:0]       rom_addr,
	output logic [lfm_pkg::AMP_W-1:0]        amplitude
);
	import lfm_pkg::*;

	localparam int CMP_W = ((COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W) + 1;

	logic [PERIOD_W-1:0]   period_q;
	logic [PULSE_W-1:0]    pulse_q;
	logic [CHIRP_W-1:0]    chirp_q;
	logic [AMP_W-1:0]      amp_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] freq_q;

	logic [COUNT_BITS-1:0] cnt_eff;
	logic [COUNT_BITS-1:0] cnt_nxt;
	logic [CMP_W-1:0]      cnt_inc;
	logic [CMP_W-1:0]      limit;
	logic                  start;
	logic                  inp;
	logic [PHASE_BITS-1:0] ph;
	logic [PHASE_BITS-1:0] fr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			pulse_q  <= PULSE_RST;
			chirp_q  <= CHIRP_RST;
			amp_q    <= AMP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				REG_PULSE:  pulse_q  <= cfg_data[PULSE_W-1:0];
				REG_CHIRP:  chirp_q  <= cfg_data[CHIRP_W-1:0];
				REG_AMP:    amp_q    <= cfg_data[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cnt_eff = restart ? '0 : cnt_q;
		start   = (cnt_eff == '0);
		ph      = start ? '0 : phase_q;
		fr      = start ? PHASE_BITS'(chirp_q >> 1) : freq_q;
		inp     = CMP_W'(cnt_eff) < CMP_W'(pulse_q);
		cnt_inc = CMP_W'(cnt_eff) + CMP_W'(1);
		// A zero period behaves as a period of one sample.
		limit   = (period_q == '0) ? CMP_W'(1) : CMP_W'(period_q);
		cnt_nxt = (cnt_inc >= limit) ? '0 : COUNT_BITS'(cnt_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			phase_q <= '0;
			freq_q  <= '0;
		end else if (acc) begin
			cnt_q <= cnt_nxt;
			if (inp) begin
				phase_q <= ph + fr;
				freq_q  <= fr + PHASE_BITS'(chirp_q);
			end else begin
				phase_q <= ph;
				freq_q  <= fr;
			end
		end
	end

	assign ctl.in_pulse     = inp;
	assign ctl.period_start = start;
	assign ctl.quad         = ph[PHASE_BITS-1 -: 2];
	assign rom_addr         = ph[PHASE_BITS-3 -: SINE_TABLE_BITS];
	assign amplitude        = amp_q;

endmodule

// File: hw/rtl/lfm_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports (entry k and its mirror).
// Depends on lfm_pkg for the series constants; contents are built at elaboration.
module lfm_sine_rom #(
	parameter int SAMPLE_BITS     = 16,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [SINE_TABLE_BITS-1:0] addr,
	output logic [SAMPLE_BITS-2:0]     rd_a,
	output logic [SAMPLE_BITS-2:0]     rd_b
);
	import lfm_pkg::*;

	localparam int ROM_SIZE = 2 ** SINE_TABLE_BITS;
	localparam int ROM_W    = SAMPLE_BITS - 1;
	localparam longint unsigned ROM_MAX = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

	typedef logic [ROM_W-1:0] rom_t [ROM_SIZE];

	// Entry k holds sin(pi/2*(2k+1)/2N) at full scale, from a Q30 Taylor series.
	function automatic rom_t build_rom();
		rom_t               tbl;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        val;
		logic signed [63:0] sum;
		for (int k = 0; k < ROM_SIZE; k++) begin
			x    = (64'(HALF_PI_Q30) * (64'(2 * k) + 64'd1)) >> (SINE_TABLE_BITS + 1);
			x2   = (x * x) >> 30;
			term = x;
			sum  = signed'(x);
			for (int n = 1; n <= 5; n++) begin
				term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n-1]);
				if (n[0])
					sum = sum - signed'(term);
				else
					sum = sum + signed'(term);
			end
			if (sum < 0)
				sum = '0;
			val    = (unsigned'(sum) * 64'(ROM_MAX) + 64'd536870912) >> 30;
			tbl[k] = ROM_W'(val);
		end
		return tbl;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			rd_a <= ROM[addr];
			rd_b <= ROM[~addr];
		end
	end

endmodule

// File: hw/rtl/lfm_scale.sv
// Output pipeline: quadrant folding, amplitude product, rounding and output register.
// Depends on lfm_pkg; its first stage lines up with the registered ROM reads.
module lfm_scale #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          take,
	input  lfm_pkg::lfm_ctl_t             ctl,
	input  logic [SAMPLE_BITS-2:0]        rom_a,
	input  logic [SAMPLE_BITS-2:0]        rom_b,
	input  logic [lfm_pkg::AMP_W-1:0]     amplitude,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] i_sample,
	output logic signed [SAMPLE_BITS-1:0] q_sample,
	output lfm_pkg::lfm_flags_t           flags
);
	import lfm_pkg::*;

	localparam int MAG_W = SAMPLE_BITS - 1 + AMP_W;

	logic       v_s1;
	logic       v_s2;
	logic       adv2;
	logic       adv3;
	lfm_ctl_t   ctl_s1;

	logic [SAMPLE_BITS-2:0] c_mag;
	logic [SAMPLE_BITS-2:0] s_mag;
	logic [MAG_W-1:0]       mag_i_s2;
	logic [MAG_W-1:0]       mag_q_s2;
	logic                   neg_i_s2;
	logic                   neg_q_s2;
	lfm_flags_t             flags_s2;

	logic [MAG_W:0]         rnd_i;
	logic [MAG_W:0]         rnd_q;
	logic [SAMPLE_BITS-1:0] r_i;
	logic [SAMPLE_BITS-1:0] r_q;

	assign adv3 = !out_valid || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign take = !v_s1 || adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take)
				v_s1 <= in_valid;
			if (adv2)
				v_s2 <= v_s1;
			if (adv3)
				out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			ctl_s1 <= ctl;
	end

	// Odd quadrants swap the roles of the entry and its mirror.
	always_comb begin
		c_mag = ctl_s1.quad[0] ? rom_a : rom_b;
		s_mag = ctl_s1.quad[0] ? rom_b : rom_a;
		if (!ctl_s1.in_pulse) begin
			c_mag = '0;
			s_mag = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			mag_i_s2              <= MAG_W'(c_mag) * MAG_W'(amplitude);
			mag_q_s2              <= MAG_W'(s_mag) * MAG_W'(amplitude);
			neg_i_s2              <= ctl_s1.quad[1] ^ ctl_s1.quad[0];
			neg_q_s2              <= ctl_s1.quad[1];
			flags_s2.in_pulse     <= ctl_s1.in_pulse;
			flags_s2.period_start <= ctl_s1.period_start;
		end
	end

	// Round half away from zero: round the magnitude, then apply the sign.
	always_comb begin
		rnd_i = (MAG_W + 1)'(mag_i_s2) + (MAG_W + 1)'(16384);
		rnd_q = (MAG_W + 1)'(mag_q_s2) + (MAG_W + 1)'(16384);
		r_i   = SAMPLE_BITS'(rnd_i >> AMP_W);
		r_q   = SAMPLE_BITS'(rnd_q >> AMP_W);
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			i_sample <= neg_i_s2 ? signed'(~r_i + 1'b1) : signed'(r_i);
			q_sample <= neg_q_s2 ? signed'(~r_q + 1'b1) : signed'(r_q);
			flags    <= flags_s2;
		end
	end

endmodule
